[rtl/core/ets_pkg.sv]
// Shared types, constants and saturation helpers of the engine thermal and speed step unit.
`default_nettype none

package ets_pkg;

   localparam int VW      = 32;          // width of every Q16.16 value
   localparam int FRAC    = 16;          // fraction bits
   localparam int WW      = 68;          // width of wide intermediates
   localparam int MW      = 34;          // multiplier operand width
   localparam int POINTS  = 16;          // torque table depth
   localparam int IDX_W   = 4;           // table address width
   localparam int CNT_W   = 5;           // search counter, holds POINTS itself
   localparam int DIV_W   = 50;          // signed dividend width
   localparam int MAG_W   = DIV_W - 1;   // dividend magnitude width
   localparam int DEN_W   = 34;          // divisor width
   localparam int DCNT_W  = $clog2(MAG_W + 1);
   localparam int POWER_DIV = 1000;

   // ceil(2**36 / 1000): exact quotient by 1000 for any value below 2**26.
   localparam int             RECIP_SHIFT = 36;
   localparam logic [26:0]    RECIP_1000  = 27'd68719477;

   typedef logic signed [VW-1:0]    value_type;
   typedef logic signed [WW-1:0]    wide_type;
   typedef logic signed [MW-1:0]    mop_type;
   typedef logic signed [DIV_W-1:0] dnum_type;
   typedef logic [DEN_W-1:0]        dden_type;

   localparam wide_type W_MAX = wide_type'(2147483647);
   localparam wide_type W_MIN = ~W_MAX;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_STEP  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_AMBIENT   = 3'd0,
      CSR_HEAT_TRQ  = 3'd1,
      CSR_HEAT_SPD  = 3'd2,
      CSR_COOLING   = 3'd3,
      CSR_INERTIA   = 3'd4,
      CSR_POINTS    = 3'd5
   } csr_addr_type;

   typedef enum logic [1:0] {
      EDGE_INSIDE,
      EDGE_LOW,
      EDGE_HIGH
   } edge_type;

   typedef enum logic [5:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_START,
      OP_RATE,
      OP_MUL_TEMP,
      OP_ADD_TEMP,
      OP_MUL_SPD,
      OP_ADD_SPD,
      OP_SEARCH,
      OP_SEG,
      OP_RD0,
      OP_RD1,
      OP_DIV_SLOPE,
      OP_SLOPE_SAT,
      OP_SLOPE_ZERO,
      OP_MUL_TRQ,
      OP_ADD_TRQ,
      OP_MUL_PWR,
      OP_DIV_PWR,
      OP_PWR_SAT,
      OP_MUL_SQ,
      OP_SQ,
      OP_MUL_H1,
      OP_H1,
      OP_MUL_H2,
      OP_HEAT,
      OP_DIFF,
      OP_MUL_COOL,
      OP_COOL,
      OP_ACC_ZERO,
      OP_DIV_ACC,
      OP_ACC_SAT
   } dp_op_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_LOAD,
      S_START,
      S_RATE,
      S_MUL_TEMP,
      S_ADD_TEMP,
      S_MUL_SPD,
      S_ADD_SPD,
      S_SEARCH,
      S_SEG,
      S_RD0,
      S_RD1,
      S_SLOPE_GO,
      S_SLOPE_WAIT,
      S_MUL_TRQ,
      S_ADD_TRQ,
      S_MUL_PWR,
      S_PWR_GO,
      S_PWR_WAIT,
      S_MUL_SQ,
      S_SQ,
      S_MUL_H1,
      S_H1,
      S_MUL_H2,
      S_HEAT,
      S_DIFF,
      S_MUL_COOL,
      S_COOL,
      S_ACC_GO,
      S_ACC_WAIT,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic search_hit;
      logic slope_rising;
      logic div_done;
      logic inertia_zero;
   } dp_status_type;

   typedef struct packed {
      value_type torque;
      value_type speed;
      value_type power;
      value_type temperature;
      logic      saturated;
   } ets_result_type;

   function automatic value_type sat_val(input wide_type x);
      value_type r;
      if (x > W_MAX)
         r = {1'b0, {(VW-1){1'b1}}};
      else if (x < W_MIN)
         r = {1'b1, {(VW-1){1'b0}}};
      else
         r = x[VW-1:0];
      return r;
   endfunction

   function automatic logic sat_hit(input wide_type x);
      return (x > W_MAX) || (x < W_MIN);
   endfunction

   function automatic wide_type widen(input value_type v);
      return wide_type'(v);
   endfunction

endpackage

`default_nettype wire

[rtl/core/ets_if.sv]
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface ets_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  point_index;
   logic signed [31:0] point_speed;
   logic signed [31:0] point_torque;
   logic [30:0] time_step;

   modport source (output valid, req_type, point_index, point_speed, point_torque, time_step,
                   input ready);
   modport sink   (input valid, req_type, point_index, point_speed, point_torque, time_step,
                   output ready);
endinterface

interface ets_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] torque;
   logic signed [31:0] speed;
   logic signed [31:0] power;
   logic signed [31:0] temperature;
   logic        saturated;

   modport source (output valid, torque, speed, power, temperature, saturated, input ready);
   modport sink   (input valid, torque, speed, power, temperature, saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/engine_thermal_speed_step_unit.sv]
// Top level of the engine thermal and speed step unit.
`default_nettype none

// The unit models an engine with a sixteen-point torque-versus-speed table and forward
// Euler integration, all in signed Q16.16 with saturation. A load transfer writes one
// table point and yields no result. A start or step transfer loads its result into the
// output register at the end of its sequence: the shared restoring divider forms the
// slope and acceleration quotients, the power is divided by 1000, and the segment search
// scans the table points in order. A flat or falling segment skips the slope division
// and zero inertia skips the acceleration division. One item is worked on at a time;
// the finished result sits in an output register, so the next request is taken while
// it waits. Configuration writes are taken at any time but must only be made while the
// unit is idle. Request type three is accepted and dropped.
module engine_thermal_speed_step_unit
   import ets_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   ets_req_if.sink          req,
   ets_rsp_if.source        rsp,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   ctrl_cmd_type   cmd;
   dp_status_type  status;
   ets_result_type result;
   ets_result_type rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;
   logic           req_ready;

   // The output register may be refilled in the cycle its contents are transferred.
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   ets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_type  (req.req_type),
      .rsp_free  (rsp_free),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   ets_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_point_index  (req.point_index),
      .in_point_speed  (req.point_speed),
      .in_point_torque (req.point_torque),
      .in_time_step    (req.time_step),
      .result          (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req.ready       = req_ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.torque      = rsp_data_ff.torque;
   assign rsp.speed       = rsp_data_ff.speed;
   assign rsp.power       = rsp_data_ff.power;
   assign rsp.temperature = rsp_data_ff.temperature;
   assign rsp.saturated   = rsp_data_ff.saturated;

endmodule

`default_nettype wire

[rtl/core/ets_divider.sv]
// Dividers: a restoring divider for variable divisors and a divider by the power scale.
`default_nettype none

module ets_divider
   import ets_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire dnum_type num,
   input  wire dden_type den,
   output logic          done,
   output dnum_type      quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   dden_type          den_ff, den_in;
   logic              neg_ff, neg_in;

   logic [DIV_W-1:0]  abs_num;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   always_comb begin
      abs_num = num[DIV_W-1] ? (~num + 1'b1) : num;
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      ge      = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(MAG_W);
         quo_in  = abs_num[MAG_W-1:0];
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[DIV_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -dnum_type'({1'b0, quo_ff}) : dnum_type'({1'b0, quo_ff});

endmodule

// Divides by 1000, sixteen dividend bits per cycle in four steps, truncating toward zero.
module ets_div1000
   import ets_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire dnum_type num,
   output logic          done,
   output dnum_type      quotient
);

   // Each cycle divides the running remainder joined to the next sixteen dividend bits,
   // a value below 1000 * 2**16, by a reciprocal multiplication that is exact there.
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [63:0]      mag_ff, mag_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [9:0]       rem_ff, rem_in;
   logic             neg_ff, neg_in;

   logic [DIV_W-1:0] abs_num;
   logic [25:0]      part;
   logic [52:0]      scaled;
   logic [15:0]      digit;
   logic [25:0]      back;

   always_comb begin
      abs_num = num[DIV_W-1] ? (~num + 1'b1) : num;
      part    = {rem_ff, mag_ff[63:48]};
      scaled  = {27'd0, part} * {26'd0, RECIP_1000};
      digit   = scaled[RECIP_SHIFT+15:RECIP_SHIFT];
      back    = part - 26'(digit) * 26'(POWER_DIV);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd3;
         mag_in  = 64'(abs_num[MAG_W-1:0]);
         quo_in  = '0;
         rem_in  = '0;
         neg_in  = num[DIV_W-1];
      end else if (busy_ff) begin
         mag_in = {mag_ff[47:0], 16'd0};
         quo_in = {quo_ff[MAG_W-17:0], digit};
         rem_in = back[9:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 2'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -dnum_type'({1'b0, quo_ff}) : dnum_type'({1'b0, quo_ff});

endmodule

`default_nettype wire

[rtl/core/ets_datapath.sv]
// Datapath: configuration, torque table, engine state, shared multiplier and divider.
`default_nettype none

module ets_datapath
   import ets_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [31:0]   csr_wdata,
   input  wire logic [3:0]    in_point_index,
   input  wire value_type     in_point_speed,
   input  wire value_type     in_point_torque,
   input  wire logic [30:0]   in_time_step,
   output ets_result_type     result
);

   // Configuration
   value_type         amb_ff, hpt_ff, hps_ff, cool_ff;
   logic [30:0]       inertia_ff;
   logic [4:0]        points_ff;

   // Captured request
   logic [IDX_W-1:0]  index_ff, index_in;
   value_type         pspd_ff, pspd_in, ptrq_ff, ptrq_in;
   logic [30:0]       dt_ff, dt_in;

   // Torque table, undefined until written
   value_type         tab_spd [POINTS];
   value_type         tab_trq [POINTS];

   // Engine state and working registers
   value_type temp_ff, temp_in, speed_ff, speed_in, torque_ff, torque_in;
   value_type heat_ff, heat_in, coolr_ff, coolr_in, accel_ff, accel_in;
   value_type power_ff, power_in, t0_ff, t0_in, t1_ff, t1_in, slope_ff, slope_in;
   value_type v0_ff, v0_in, v1_ff, v1_in, m0_ff, m0_in, m1_ff, m1_in;
   logic              flag_ff, flag_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   edge_type          edge_ff, edge_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   wide_type          prod_ff, prod_in;

   logic [CNT_W-1:0]  n_pts;
   logic [IDX_W-1:0]  rd_addr;
   value_type         rd_spd, rd_trq;
   mop_type           mul_a, mul_b;
   logic              mul_en;
   wide_type          prod_q, s, s2;
   value_type         h2;
   logic              div_start;
   dnum_type          div_num, div_q;
   dden_type          div_den;
   logic              div_done;
   logic              pdiv_start;
   dnum_type          pdiv_q;
   logic              pdiv_done;
   logic              hit;

   ets_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // The power scale divides by a constant, so it has its own short unit.
   ets_div1000 u_pdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (pdiv_start),
      .num      (div_num),
      .done     (pdiv_done),
      .quotient (pdiv_q)
   );

   // Points in use, clamped to the table span.
   always_comb begin
      if (points_ff < CNT_W'(2))
         n_pts = CNT_W'(2);
      else if (points_ff > CNT_W'(POINTS))
         n_pts = CNT_W'(POINTS);
      else
         n_pts = points_ff;
   end

   always_comb begin
      if (cmd.op == OP_RD1)
         rd_addr = lo_ff + 1'b1;
      else if (cmd.op == OP_SEARCH)
         rd_addr = idx_ff[IDX_W-1:0];
      else
         rd_addr = lo_ff;
      rd_spd = tab_spd[rd_addr];
      rd_trq = tab_trq[rd_addr];
      hit    = (idx_ff == n_pts) || (rd_spd > speed_ff);
   end

   assign prod_q = prod_ff >>> FRAC;

   always_comb begin
      index_in = index_ff; pspd_in = pspd_ff; ptrq_in = ptrq_ff; dt_in = dt_ff;
      temp_in = temp_ff; speed_in = speed_ff; torque_in = torque_ff;
      heat_in = heat_ff; coolr_in = coolr_ff; accel_in = accel_ff;
      power_in = power_ff; t0_in = t0_ff; t1_in = t1_ff; slope_in = slope_ff;
      v0_in = v0_ff; v1_in = v1_ff; m0_in = m0_ff; m1_in = m1_ff;
      flag_in = flag_ff; lo_in = lo_ff; edge_in = edge_ff; idx_in = idx_ff;
      mul_a = '0; mul_b = '0; mul_en = 1'b0;
      div_start = 1'b0; div_num = '0; div_den = '0; pdiv_start = 1'b0;
      s = '0; s2 = '0; h2 = '0;

      unique case (cmd.op)
         OP_NONE, OP_LOAD: ;
         OP_CAPTURE: begin
            index_in = in_point_index;
            pspd_in  = in_point_speed;
            ptrq_in  = in_point_torque;
            dt_in    = in_time_step;
         end
         OP_START: begin
            temp_in  = amb_ff;
            speed_in = '0;
            flag_in  = 1'b0;
            idx_in   = '0;
         end
         OP_RATE: begin
            s       = widen(heat_ff) + widen(coolr_ff);
            t0_in   = sat_val(s);
            flag_in = sat_hit(s);
         end
         OP_MUL_TEMP: begin
            mul_a = mop_type'(t0_ff); mul_b = mop_type'(dt_ff); mul_en = 1'b1;
         end
         OP_ADD_TEMP: begin
            s       = widen(temp_ff) + prod_q;
            temp_in = sat_val(s);
            flag_in = flag_ff | sat_hit(s);
         end
         OP_MUL_SPD: begin
            mul_a = mop_type'(accel_ff); mul_b = mop_type'(dt_ff); mul_en = 1'b1;
         end
         OP_ADD_SPD: begin
            s        = widen(speed_ff) + prod_q;
            speed_in = sat_val(s);
            flag_in  = flag_ff | sat_hit(s);
            idx_in   = '0;
         end
         OP_SEARCH: begin
            if (!hit)
               idx_in = idx_ff + 1'b1;
         end
         OP_SEG: begin
            if (idx_ff == '0) begin
               lo_in = '0; edge_in = EDGE_LOW;
            end else if (idx_ff == n_pts) begin
               lo_in = IDX_W'(n_pts - CNT_W'(2)); edge_in = EDGE_HIGH;
            end else begin
               lo_in = IDX_W'(idx_ff - 1'b1); edge_in = EDGE_INSIDE;
            end
         end
         OP_RD0: begin
            v0_in = rd_spd; m0_in = rd_trq;
            if (edge_ff == EDGE_LOW)
               speed_in = rd_spd;
         end
         OP_RD1: begin
            v1_in = rd_spd; m1_in = rd_trq;
            if (edge_ff == EDGE_HIGH)
               speed_in = rd_spd;
         end
         OP_DIV_SLOPE: begin
            div_start = 1'b1;
            s         = (widen(m1_ff) - widen(m0_ff)) <<< FRAC;
            div_num   = s[DIV_W-1:0];
            s2        = widen(v1_ff) - widen(v0_ff);
            div_den   = s2[DEN_W-1:0];
         end
         OP_SLOPE_SAT: begin
            s        = wide_type'(div_q);
            slope_in = sat_val(s);
            flag_in  = flag_ff | sat_hit(s);
         end
         OP_SLOPE_ZERO: slope_in = '0;
         OP_MUL_TRQ: begin
            s     = widen(speed_ff) - widen(v0_ff);
            mul_a = mop_type'(slope_ff); mul_b = s[MW-1:0]; mul_en = 1'b1;
         end
         OP_ADD_TRQ: begin
            s         = widen(m0_ff) + prod_q;
            torque_in = sat_val(s);
            flag_in   = flag_ff | sat_hit(s);
         end
         OP_MUL_PWR: begin
            mul_a = mop_type'(torque_ff); mul_b = mop_type'(speed_ff); mul_en = 1'b1;
         end
         OP_DIV_PWR: begin
            pdiv_start = 1'b1;
            div_num    = prod_q[DIV_W-1:0];
         end
         OP_PWR_SAT: begin
            s        = wide_type'(pdiv_q);
            power_in = sat_val(s);
            flag_in  = flag_ff | sat_hit(s);
         end
         OP_MUL_SQ: begin
            mul_a = mop_type'(speed_ff); mul_b = mop_type'(speed_ff); mul_en = 1'b1;
         end
         OP_SQ: begin
            t0_in   = sat_val(prod_q);
            flag_in = flag_ff | sat_hit(prod_q);
         end
         OP_MUL_H1: begin
            mul_a = mop_type'(torque_ff); mul_b = mop_type'(hpt_ff); mul_en = 1'b1;
         end
         OP_H1: begin
            t1_in   = sat_val(prod_q);
            flag_in = flag_ff | sat_hit(prod_q);
         end
         OP_MUL_H2: begin
            mul_a = mop_type'(t0_ff); mul_b = mop_type'(hps_ff); mul_en = 1'b1;
         end
         OP_HEAT: begin
            h2      = sat_val(prod_q);
            s       = widen(t1_ff) + widen(h2);
            heat_in = sat_val(s);
            flag_in = flag_ff | sat_hit(prod_q) | sat_hit(s);
         end
         OP_DIFF: begin
            s       = widen(amb_ff) - widen(temp_ff);
            t0_in   = sat_val(s);
            flag_in = flag_ff | sat_hit(s);
         end
         OP_MUL_COOL: begin
            mul_a = mop_type'(cool_ff); mul_b = mop_type'(t0_ff); mul_en = 1'b1;
         end
         OP_COOL: begin
            coolr_in = sat_val(prod_q);
            flag_in  = flag_ff | sat_hit(prod_q);
         end
         OP_ACC_ZERO: begin
            if (torque_ff > 0) begin
               accel_in = {1'b0, {(VW-1){1'b1}}}; flag_in = 1'b1;
            end else if (torque_ff < 0) begin
               accel_in = {1'b1, {(VW-1){1'b0}}}; flag_in = 1'b1;
            end else begin
               accel_in = '0;
            end
         end
         OP_DIV_ACC: begin
            div_start = 1'b1;
            s         = widen(torque_ff) <<< FRAC;
            div_num   = s[DIV_W-1:0];
            div_den   = DEN_W'(inertia_ff);
         end
         OP_ACC_SAT: begin
            s        = wide_type'(div_q);
            accel_in = sat_val(s);
            flag_in  = flag_ff | sat_hit(s);
         end
         default: ;
      endcase

      prod_in = mul_en ? wide_type'(mul_a * mul_b) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amb_ff     <= '0;
         hpt_ff     <= '0;
         hps_ff     <= '0;
         cool_ff    <= '0;
         inertia_ff <= 31'd65536;
         points_ff  <= 5'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AMBIENT:  amb_ff     <= csr_wdata;
            CSR_HEAT_TRQ: hpt_ff     <= csr_wdata;
            CSR_HEAT_SPD: hps_ff     <= csr_wdata;
            CSR_COOLING:  cool_ff    <= csr_wdata;
            CSR_INERTIA:  inertia_ff <= csr_wdata[30:0];
            CSR_POINTS:   points_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         tab_spd[index_ff] <= pspd_ff;
         tab_trq[index_ff] <= ptrq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff   <= '0;
         speed_ff  <= '0;
         torque_ff <= '0;
         heat_ff   <= '0;
         coolr_ff  <= '0;
         accel_ff  <= '0;
         flag_ff   <= 1'b0;
         idx_ff    <= '0;
         edge_ff   <= EDGE_INSIDE;
      end else begin
         temp_ff   <= temp_in;
         speed_ff  <= speed_in;
         torque_ff <= torque_in;
         heat_ff   <= heat_in;
         coolr_ff  <= coolr_in;
         accel_ff  <= accel_in;
         flag_ff   <= flag_in;
         idx_ff    <= idx_in;
         edge_ff   <= edge_in;
      end
      index_ff <= index_in;
      pspd_ff  <= pspd_in;
      ptrq_ff  <= ptrq_in;
      dt_ff    <= dt_in;
      power_ff <= power_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      slope_ff <= slope_in;
      v0_ff    <= v0_in;
      v1_ff    <= v1_in;
      m0_ff    <= m0_in;
      m1_ff    <= m1_in;
      lo_ff    <= lo_in;
      prod_ff  <= prod_in;
   end

   always_comb begin
      status.search_hit   = hit;
      status.slope_rising = v1_ff > v0_ff;
      status.div_done     = div_done | pdiv_done;
      status.inertia_zero = (inertia_ff == '0);
      result.torque       = torque_ff;
      result.speed        = speed_ff;
      result.power        = power_ff;
      result.temperature  = temp_ff;
      result.saturated    = flag_ff;
   end

endmodule

`default_nettype wire

[rtl/core/ets_ctrl.sv]
// Sequencer that steps the datapath through one load, start or time step.
`default_nettype none

module ets_ctrl
   import ets_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [1:0]    req_type,
   input  wire logic          rsp_free,
   input  wire dp_status_type status,
   output logic               req_ready,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind_type'(req_type))
                  REQ_LOAD:  state_in = S_LOAD;
                  REQ_START: state_in = S_START;
                  REQ_STEP:  state_in = S_RATE;
                  REQ_NONE:  state_in = S_IDLE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD:       state_in = S_IDLE;
         S_START:      state_in = S_SEARCH;
         S_RATE:       state_in = S_MUL_TEMP;
         S_MUL_TEMP:   state_in = S_ADD_TEMP;
         S_ADD_TEMP:   state_in = S_MUL_SPD;
         S_MUL_SPD:    state_in = S_ADD_SPD;
         S_ADD_SPD:    state_in = S_SEARCH;
         S_SEARCH:     if (status.search_hit) state_in = S_SEG;
         S_SEG:        state_in = S_RD0;
         S_RD0:        state_in = S_RD1;
         S_RD1:        state_in = S_SLOPE_GO;
         S_SLOPE_GO:   state_in = status.slope_rising ? S_SLOPE_WAIT : S_MUL_TRQ;
         S_SLOPE_WAIT: if (status.div_done) state_in = S_MUL_TRQ;
         S_MUL_TRQ:    state_in = S_ADD_TRQ;
         S_ADD_TRQ:    state_in = S_MUL_PWR;
         S_MUL_PWR:    state_in = S_PWR_GO;
         S_PWR_GO:     state_in = S_PWR_WAIT;
         S_PWR_WAIT:   if (status.div_done) state_in = S_MUL_SQ;
         S_MUL_SQ:     state_in = S_SQ;
         S_SQ:         state_in = S_MUL_H1;
         S_MUL_H1:     state_in = S_H1;
         S_H1:         state_in = S_MUL_H2;
         S_MUL_H2:     state_in = S_HEAT;
         S_HEAT:       state_in = S_DIFF;
         S_DIFF:       state_in = S_MUL_COOL;
         S_MUL_COOL:   state_in = S_COOL;
         S_COOL:       state_in = S_ACC_GO;
         S_ACC_GO:     state_in = status.inertia_zero ? S_DONE : S_ACC_WAIT;
         S_ACC_WAIT:   if (status.div_done) state_in = S_DONE;
         S_DONE:       if (rsp_free) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      cmd.rsp_load = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid)
               cmd.op = OP_CAPTURE;
         end
         S_LOAD:       cmd.op = OP_LOAD;
         S_START:      cmd.op = OP_START;
         S_RATE:       cmd.op = OP_RATE;
         S_MUL_TEMP:   cmd.op = OP_MUL_TEMP;
         S_ADD_TEMP:   cmd.op = OP_ADD_TEMP;
         S_MUL_SPD:    cmd.op = OP_MUL_SPD;
         S_ADD_SPD:    cmd.op = OP_ADD_SPD;
         S_SEARCH:     cmd.op = OP_SEARCH;
         S_SEG:        cmd.op = OP_SEG;
         S_RD0:        cmd.op = OP_RD0;
         S_RD1:        cmd.op = OP_RD1;
         S_SLOPE_GO:   cmd.op = status.slope_rising ? OP_DIV_SLOPE : OP_SLOPE_ZERO;
         S_SLOPE_WAIT: if (status.div_done) cmd.op = OP_SLOPE_SAT;
         S_MUL_TRQ:    cmd.op = OP_MUL_TRQ;
         S_ADD_TRQ:    cmd.op = OP_ADD_TRQ;
         S_MUL_PWR:    cmd.op = OP_MUL_PWR;
         S_PWR_GO:     cmd.op = OP_DIV_PWR;
         S_PWR_WAIT:   if (status.div_done) cmd.op = OP_PWR_SAT;
         S_MUL_SQ:     cmd.op = OP_MUL_SQ;
         S_SQ:         cmd.op = OP_SQ;
         S_MUL_H1:     cmd.op = OP_MUL_H1;
         S_H1:         cmd.op = OP_H1;
         S_MUL_H2:     cmd.op = OP_MUL_H2;
         S_HEAT:       cmd.op = OP_HEAT;
         S_DIFF:       cmd.op = OP_DIFF;
         S_MUL_COOL:   cmd.op = OP_MUL_COOL;
         S_COOL:       cmd.op = OP_COOL;
         S_ACC_GO:     cmd.op = status.inertia_zero ? OP_ACC_ZERO : OP_DIV_ACC;
         S_ACC_WAIT:   if (status.div_done) cmd.op = OP_ACC_SAT;
         S_DONE:       cmd.rsp_load = rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

endmodule

`default_nettype wire
